// ===== rtl/dat_pkg.sv =====
`default_nettype none
package dat_pkg;

  localparam int MAX_OUT = 16;
  localparam int FIRE_W  = 5;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FIRED     = 3'd4;
  localparam logic [2:0] ST_NONE_DUE  = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        due_time;
    logic signed [31:0] alarm_weight;
    logic [31:0]        current_time;
  } dat_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        fired_time;
    logic signed [31:0] fired_weight;
    logic               last;
  } dat_res_t;

  typedef struct packed {
    logic load;
    logic add;
    logic scan;
    logic finish;
  } dat_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dat_sts_t;

endpackage
`default_nettype wire

// ===== rtl/dat_ctrl.sv =====
`default_nettype none
module dat_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       req_type,
  input  wire dat_pkg::dat_sts_t sts,
  output dat_pkg::dat_cmd_t     cmd,
  output logic                  busy
);
  import dat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (req_type)
            REQ_ADD:          state_nxt = S_ADD;
            REQ_DEL, REQ_TICK: state_nxt = S_SCAN;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/dat_datapath.sv =====
`default_nettype none
module dat_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dat_pkg::dat_req_t in_req,
  input  wire dat_pkg::dat_cmd_t cmd,
  output dat_pkg::dat_sts_t      sts,
  output logic                   out_valid,
  output dat_pkg::dat_res_t      out_result
);
  import dat_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [63:0] mem [TABLE_DEPTH];

  dat_req_t          req_r, req_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_r, rd_nxt;
  logic [CW-1:0]     wr_r, wr_nxt;
  logic [FIRE_W-1:0] nfire_r, nfire_nxt;
  logic              found_r, found_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [63:0]       rdata_r;
  logic              pend_v_r, pend_v_nxt;
  logic [63:0]       pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  dat_res_t          out_res_r, out_res_nxt;

  logic              rd_en;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [63:0]       mem_wdata;
  logic              is_tick;
  logic              hit;

  assign is_tick = (req_r.req_type == REQ_TICK);
  // tick removes due entries up to the output cap; delete removes first match only
  assign hit = is_tick
             ? ((rdata_r[63:32] <= req_r.current_time) && (nfire_r < FIRE_W'(MAX_OUT)))
             : (!found_r && (rdata_r[63:32] == req_r.due_time));

  assign sts.scan_done = (rd_r == count_r) && !rvalid_r;

  always_comb begin
    req_nxt       = req_r;
    count_nxt     = count_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    nfire_nxt     = nfire_r;
    found_nxt     = found_r;
    rvalid_nxt    = rvalid_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wr_r[AW-1:0];
    mem_wdata     = rdata_r;

    if (cmd.load) begin
      req_nxt    = in_req;
      rd_nxt     = '0;
      wr_nxt     = '0;
      nfire_nxt  = '0;
      found_nxt  = 1'b0;
      rvalid_nxt = 1'b0;
      pend_v_nxt = 1'b0;
    end

    if (cmd.add) begin
      out_valid_nxt            = 1'b1;
      out_res_nxt.fired_time   = '0;
      out_res_nxt.fired_weight = '0;
      out_res_nxt.last         = 1'b1;
      if (count_r < CW'(TABLE_DEPTH)) begin
        mem_we             = 1'b1;
        mem_waddr          = count_r[AW-1:0];
        mem_wdata          = {req_r.due_time, req_r.alarm_weight};
        count_nxt          = count_r + CW'(1);
        out_res_nxt.status = ST_ADDED;
      end else begin
        out_res_nxt.status = ST_FULL;
      end
    end

    if (cmd.scan) begin
      rvalid_nxt = (rd_r < count_r);
      if (rd_r < count_r) begin
        rd_en  = 1'b1;
        rd_nxt = rd_r + CW'(1);
      end
      if (rvalid_r) begin
        if (hit) begin
          if (is_tick) begin
            if (pend_v_r) begin
              out_valid_nxt            = 1'b1;
              out_res_nxt.status       = ST_FIRED;
              out_res_nxt.fired_time   = pend_r[63:32];
              out_res_nxt.fired_weight = $signed(pend_r[31:0]);
              out_res_nxt.last         = 1'b0;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = rdata_r;
            nfire_nxt  = nfire_r + FIRE_W'(1);
          end else begin
            found_nxt = 1'b1;
          end
        end else begin
          // kept entry slides down into the gap
          mem_we = 1'b1;
          wr_nxt = wr_r + CW'(1);
        end
      end
    end

    if (cmd.finish) begin
      count_nxt                = wr_r;
      out_valid_nxt            = 1'b1;
      out_res_nxt.fired_time   = '0;
      out_res_nxt.fired_weight = '0;
      out_res_nxt.last         = 1'b1;
      if (is_tick) begin
        if (pend_v_r) begin
          out_res_nxt.status       = ST_FIRED;
          out_res_nxt.fired_time   = pend_r[63:32];
          out_res_nxt.fired_weight = $signed(pend_r[31:0]);
        end else begin
          out_res_nxt.status = ST_NONE_DUE;
        end
      end else begin
        out_res_nxt.status = found_r ? ST_DELETED : ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en)  rdata_r <= mem[rd_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rd_r        <= '0;
      wr_r        <= '0;
      nfire_r     <= '0;
    end else begin
      count_r     <= count_nxt;
      rvalid_r    <= rvalid_nxt;
      pend_v_r    <= pend_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      nfire_r     <= nfire_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

endmodule
`default_nettype wire

// ===== rtl/due_alarm_table.sv =====
`default_nettype none
// Pending alarm table, up to TABLE_DEPTH entries of due time and weight in
// insertion order.
// Input: drive in_req and pulse start while busy is low; the item is taken
// at that edge. busy stays high until the request has finished.
// Output: each result shows on out_result for one cycle with out_valid high;
// there is no backpressure, the receiver must take it as it comes.
// Add: one result (added or full); busy is high only in the add state.
// Delete/tick: the table sits in a single-port-read RAM and is walked one
// entry per cycle, compacting in place. Fired alarms come out in table
// order during the walk, each held back until the next hit or the end of
// the walk so the final one can carry last; a tick with nothing due yields
// one none-due result.
// req_type 3 is taken and dropped with no result.
// Reset empties the table (count cleared, no RAM sweep) and drops any work.
module due_alarm_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire dat_pkg::dat_req_t in_req,
  output logic                   out_valid,
  output dat_pkg::dat_res_t      out_result
);
  import dat_pkg::*;

  dat_cmd_t cmd;
  dat_sts_t sts;

  dat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  dat_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule
`default_nettype wire

// ===== rtl/dat_checker.sv =====
`default_nettype none
module dat_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire dat_pkg::dat_req_t in_req,
  input wire logic              out_valid,
  input wire dat_pkg::dat_res_t out_result
);
  import dat_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((in_req.req_type == REQ_ADD) || (in_req.req_type == REQ_DEL) ||
               (in_req.req_type == REQ_TICK)) |=> busy)
    else $error("busy not raised after a request");

  a_no_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid)
    else $error("result right after accept");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result.status != ST_FIRED) |->
      out_result.last && (out_result.fired_time == '0) && (out_result.fired_weight == '0))
    else $error("non-fired result malformed");

  a_more_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result.last |-> busy)
    else $error("request ended before last result");

endmodule

bind due_alarm_table dat_checker u_dat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_valid  (out_valid),
  .out_result (out_result)
);
`default_nettype wire
